// ===== hdl/epoch_seconds_to_calendar_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the epoch seconds to calendar converter
// Shared property shapes, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define ESC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("esc assertion failed");

// Check a consequent in the cycle after its antecedent.
`define ESC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("esc assertion failed");

`endif

// ===== hdl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Constants of the epoch seconds to calendar converter: day offsets and the
// reciprocal multipliers that replace division by fixed divisors.
// ----------------------------------------------------------------------------
package esc_pkg;

   // Bias that makes the seconds count non-negative (a whole number of days)
   localparam longint unsigned BIAS_DAYS = 49711;
   localparam longint unsigned SEC_BIAS  = BIAS_DAYS * 86400;

   // Days from 1600-03-01 to 1970-01-01, minus the bias days
   localparam longint unsigned DOE_BIAS = 135080 - BIAS_DAYS;
   localparam longint unsigned ERA_DAYS = 146097;

   // Exact floor division: x / D == (x * ceil(2^K / D)) >> K for K = n + ceil(log2 D)
   localparam int K675   = 37;
   localparam int K3600  = 29;
   localparam int K1460  = 29;
   localparam int K36524 = 34;
   localparam int K60    = 18;
   localparam int K365   = 27;
   localparam int K100   = 16;
   localparam int K153   = 19;
   localparam int K5     = 14;

   localparam longint unsigned M675   = ((64'd1 << K675) + 675 - 1) / 675;
   localparam longint unsigned M3600  = ((64'd1 << K3600) + 3600 - 1) / 3600;
   localparam longint unsigned M1460  = ((64'd1 << K1460) + 1460 - 1) / 1460;
   localparam longint unsigned M36524 = ((64'd1 << K36524) + 36524 - 1) / 36524;
   localparam longint unsigned M60    = ((64'd1 << K60) + 60 - 1) / 60;
   localparam longint unsigned M365   = ((64'd1 << K365) + 365 - 1) / 365;
   localparam longint unsigned M100   = ((64'd1 << K100) + 100 - 1) / 100;
   localparam longint unsigned M153   = ((64'd1 << K153) + 153 - 1) / 153;
   localparam longint unsigned M5     = ((64'd1 << K5) + 5 - 1) / 5;

   // Field limits
   localparam int MONTH_MAX  = 12;
   localparam int DAY_MAX    = 31;
   localparam int FEB_MAX    = 29;
   localparam int HOUR_MAX   = 23;
   localparam int MINUTE_MAX = 59;
   localparam int MONTH_FEB  = 2;

endpackage

// ===== hdl/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts signed seconds since 1970-01-01 00:00:00 into proleptic Gregorian
// year, month, day, hour, minute and second through a twelve-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | req_epoch_seconds (33b signed)
//  rsp     | out       | rsp_valid/stall    | year, month, day, hour, minute, second
//
// An accepted req beat moves through every stage register to its rsp beat; one
// beat may enter every cycle while req_stall is low.
// Synchronous reset clears the stage valid bits only.
// A stalled rsp beat freezes the whole pipeline and raises req_stall.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [32:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   localparam int STAGES = 12;

   logic              advance;
   logic [STAGES-1:0] vld_ff, vld_in;

   // stage 1: biased seconds split at 2^7
   logic [26:0] v1_ff, v1_in;
   logic [6:0]  lo1_ff, lo1_in;
   logic [33:0] biased;
   // stage 2: quotient product for /675
   logic [54:0] pq2_ff, pq2_in;
   logic [26:0] v2_ff;
   logic [6:0]  lo2_ff;
   // stage 3: day count and second of day
   logic [17:0] doeall3_ff, doeall3_in;
   logic [16:0] sod3_ff, sod3_in;
   logic [16:0] q3;
   logic [26:0] r3;
   // stage 4: era fold, hour product
   logic [17:0] doe4_ff, doe4_in;
   logic        era4_ff, era4_in;
   logic [34:0] ph4_ff, ph4_in;
   logic [16:0] sod4_ff;
   // stage 5: century products, hour
   logic [36:0] p1_5_ff, p1_5_in, p2_5_ff, p2_5_in;
   logic [17:0] doe5_ff;
   logic        era5_ff;
   logic [4:0]  hour5_ff, hour5_in;
   logic [11:0] remh5_ff, remh5_in;
   logic [16:0] hsec5;
   // stage 6: year-of-era numerator, minute product
   logic [17:0] a6_ff, a6_in;
   logic [17:0] doe6_ff;
   logic        era6_ff;
   logic [4:0]  hour6_ff;
   logic [24:0] pm6_ff, pm6_in;
   logic [11:0] remh6_ff;
   // stage 7: year product, minute and second
   logic [36:0] py7_ff, py7_in;
   logic [17:0] doe7_ff;
   logic        era7_ff;
   logic [4:0]  hour7_ff;
   logic [5:0]  min7_ff, min7_in, sec7_ff, sec7_in;
   logic [11:0] msec7;
   // stage 8: year of era and its century product
   logic [8:0]  yoe8_ff, yoe8_in;
   logic [18:0] pc8_ff, pc8_in;
   logic [17:0] doe8_ff;
   logic        era8_ff;
   logic [4:0]  hour8_ff;
   logic [5:0]  min8_ff, sec8_ff;
   // stage 9: day of year (March based)
   logic [8:0]  doy9_ff, doy9_in;
   logic [8:0]  yoe9_ff;
   logic        era9_ff;
   logic [4:0]  hour9_ff;
   logic [5:0]  min9_ff, sec9_ff;
   logic [17:0] ydays9;
   // stage 10: month product
   logic [22:0] pmp10_ff, pmp10_in;
   logic [10:0] t10;
   logic [8:0]  doy10_ff, yoe10_ff;
   logic        era10_ff;
   logic [4:0]  hour10_ff;
   logic [5:0]  min10_ff, sec10_ff;
   // stage 11: month index and its start-of-month product
   logic [3:0]  mp11_ff, mp11_in;
   logic [22:0] p5_11_ff, p5_11_in;
   logic [10:0] u11;
   logic [8:0]  doy11_ff, yoe11_ff;
   logic        era11_ff;
   logic [4:0]  hour11_ff;
   logic [5:0]  min11_ff, sec11_ff;
   // stage 12: output register
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [8:0]  mstart12;
   logic [4:0]  hour12_ff;
   logic [5:0]  min12_ff, sec12_ff;

   // Hold every stage while the output beat is stalled
   assign advance   = !(vld_ff[STAGES-1] && rsp_stall);
   assign req_stall = !advance;

   // Shift the valid bits with the data
   always_comb begin
      vld_in = {vld_ff[STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: bias to a non-negative count, split off the power-of-two factor
   always_comb begin
      biased = {req_epoch_seconds[32], req_epoch_seconds} + 34'(esc_pkg::SEC_BIAS);
      v1_in  = biased[33:7];
      lo1_in = biased[6:0];
   end

   // Stage 2: multiply by reciprocal of 675
   assign pq2_in = 55'(v1_ff) * 55'(esc_pkg::M675);

   // Stage 3: days and second of day
   always_comb begin
      q3         = pq2_ff[53:37];
      r3         = v2_ff - 27'(q3) * 27'd675;
      sod3_in    = {r3[9:0], lo2_ff};
      doeall3_in = 18'(q3) + 18'(esc_pkg::DOE_BIAS);
   end

   // Stage 4: fold into one 400-year era, start hour division
   always_comb begin
      era4_in = doeall3_ff >= 18'(esc_pkg::ERA_DAYS);
      doe4_in = era4_in ? doeall3_ff - 18'(esc_pkg::ERA_DAYS) : doeall3_ff;
      ph4_in  = 35'(sod3_ff) * 35'(esc_pkg::M3600);
   end

   // Stage 5: century products, hour and its remainder
   always_comb begin
      p1_5_in  = 37'(doe4_ff) * 37'(esc_pkg::M1460);
      p2_5_in  = 37'(doe4_ff) * 37'(esc_pkg::M36524);
      hour5_in = ph4_ff[33:29];
      hsec5    = 17'(hour5_in) * 17'd3600;
      remh5_in = 12'(sod4_ff - hsec5);
   end

   // Stage 6: remove leap days from the era day count, start minute division
   always_comb begin
      a6_in  = doe5_ff - 18'(p1_5_ff[36:29]) + 18'(p2_5_ff[36:34])
               - 18'(doe5_ff == 18'(esc_pkg::ERA_DAYS - 1));
      pm6_in = 25'(remh5_ff) * 25'(esc_pkg::M60);
   end

   // Stage 7: year product, minute and second
   always_comb begin
      py7_in  = 37'(a6_ff) * 37'(esc_pkg::M365);
      min7_in = pm6_ff[23:18];
      msec7   = 12'(min7_in) * 12'd60;
      sec7_in = 6'(remh6_ff - msec7);
   end

   // Stage 8: year of era, century count product
   always_comb begin
      yoe8_in = py7_ff[35:27];
      pc8_in  = 19'(yoe8_in) * 19'(esc_pkg::M100);
   end

   // Stage 9: day of year counted from March 1
   always_comb begin
      ydays9  = 18'(yoe8_ff) * 18'd365 + 18'(yoe8_ff[8:2]) - 18'(pc8_ff[18:16]);
      doy9_in = 9'(doe8_ff - ydays9);
   end

   // Stage 10: month product
   always_comb begin
      t10      = 11'(doy9_ff) * 11'd5 + 11'd2;
      pmp10_in = 23'(t10) * 23'(esc_pkg::M153);
   end

   // Stage 11: month index from March, start-of-month product
   always_comb begin
      mp11_in  = pmp10_ff[22:19];
      u11      = 11'(mp11_in) * 11'd153 + 11'd2;
      p5_11_in = 23'(u11) * 23'(esc_pkg::M5);
   end

   // Stage 12: day, month and year
   always_comb begin
      mstart12 = p5_11_ff[22:14];
      day_in   = 5'(doy11_ff - mstart12 + 9'd1);
      month_in = (mp11_ff < 4'd10) ? mp11_ff + 4'd3 : mp11_ff - 4'd9;
      year_in  = 12'd1600 + 12'(yoe11_ff) + (era11_ff ? 12'd400 : 12'd0)
                 + 12'(month_in <= 4'(esc_pkg::MONTH_FEB));
   end

   // Advance the payload registers together
   always_ff @(posedge clock) begin
      if (advance) begin
         v1_ff      <= v1_in;
         lo1_ff     <= lo1_in;
         pq2_ff     <= pq2_in;
         v2_ff      <= v1_ff;
         lo2_ff     <= lo1_ff;
         doeall3_ff <= doeall3_in;
         sod3_ff    <= sod3_in;
         doe4_ff    <= doe4_in;
         era4_ff    <= era4_in;
         ph4_ff     <= ph4_in;
         sod4_ff    <= sod3_ff;
         p1_5_ff    <= p1_5_in;
         p2_5_ff    <= p2_5_in;
         doe5_ff    <= doe4_ff;
         era5_ff    <= era4_ff;
         hour5_ff   <= hour5_in;
         remh5_ff   <= remh5_in;
         a6_ff      <= a6_in;
         doe6_ff    <= doe5_ff;
         era6_ff    <= era5_ff;
         hour6_ff   <= hour5_ff;
         pm6_ff     <= pm6_in;
         remh6_ff   <= remh5_ff;
         py7_ff     <= py7_in;
         doe7_ff    <= doe6_ff;
         era7_ff    <= era6_ff;
         hour7_ff   <= hour6_ff;
         min7_ff    <= min7_in;
         sec7_ff    <= sec7_in;
         yoe8_ff    <= yoe8_in;
         pc8_ff     <= pc8_in;
         doe8_ff    <= doe7_ff;
         era8_ff    <= era7_ff;
         hour8_ff   <= hour7_ff;
         min8_ff    <= min7_ff;
         sec8_ff    <= sec7_ff;
         doy9_ff    <= doy9_in;
         yoe9_ff    <= yoe8_ff;
         era9_ff    <= era8_ff;
         hour9_ff   <= hour8_ff;
         min9_ff    <= min8_ff;
         sec9_ff    <= sec8_ff;
         pmp10_ff   <= pmp10_in;
         doy10_ff   <= doy9_ff;
         yoe10_ff   <= yoe9_ff;
         era10_ff   <= era9_ff;
         hour10_ff  <= hour9_ff;
         min10_ff   <= min9_ff;
         sec10_ff   <= sec9_ff;
         mp11_ff    <= mp11_in;
         p5_11_ff   <= p5_11_in;
         doy11_ff   <= doy10_ff;
         yoe11_ff   <= yoe10_ff;
         era11_ff   <= era10_ff;
         hour11_ff  <= hour10_ff;
         min11_ff   <= min10_ff;
         sec11_ff   <= sec10_ff;
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         hour12_ff  <= hour11_ff;
         min12_ff   <= min11_ff;
         sec12_ff   <= sec11_ff;
      end
   end

   // Drive the rsp beat from the last stage
   assign rsp_valid  = vld_ff[STAGES-1];
   assign rsp_year   = year_ff;
   assign rsp_month  = month_ff;
   assign rsp_day    = day_ff;
   assign rsp_hour   = hour12_ff;
   assign rsp_minute = min12_ff;
   assign rsp_second = sec12_ff;

endmodule

// ===== hdl/esc_checker.sv =====
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks of the epoch seconds to calendar converter, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_assert.svh"

module esc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [32:0] req_epoch_seconds,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second
);

   // A stalled rsp beat holds its valid, year, month, day and second
   `ESC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_year) && $stable(rsp_month) && $stable(rsp_day) && $stable(rsp_second))

   // Back-pressure reaches the req side only from a stalled rsp beat
   `ESC_ASSERT_NOW(a_req_stall_src, req_stall, rsp_valid && rsp_stall)

   // Month, hour, minute and second of a beat are in range, and day is at least 1
   `ESC_ASSERT_NOW(a_fields_range, rsp_valid, rsp_month >= 4'd1 && rsp_month <= 4'(esc_pkg::MONTH_MAX) && rsp_day >= 5'd1 && rsp_hour <= 5'(esc_pkg::HOUR_MAX) && rsp_minute <= 6'(esc_pkg::MINUTE_MAX) && rsp_second <= 6'(esc_pkg::MINUTE_MAX))

   // February never runs past its leap day
   `ESC_ASSERT_NOW(a_feb_days, rsp_valid && rsp_month == 4'(esc_pkg::MONTH_FEB), rsp_day <= 5'(esc_pkg::FEB_MAX))

   // Short months never show day 31
   `ESC_ASSERT_NOW(a_short_month, rsp_valid && rsp_day == 5'(esc_pkg::DAY_MAX), rsp_month != 4'd4 && rsp_month != 4'd6 && rsp_month != 4'd9 && rsp_month != 4'd11)

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);
